// ----- rtl/core/nearest_palette_color_assert.svh -----
// Assertion macros for the nearest palette color block.
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define NPC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("nearest_palette_color assertion failed");

// Check a property on every clock edge, reset included.
`define NPC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("nearest_palette_color assertion failed");

`endif

// ----- rtl/core/npc_pkg.sv -----
package npc_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int ADDRESSABLE_ENTRIES   = 256;

   localparam int COLOR_W = 8;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;
   // Largest distance is 3 * 255 = 765.
   localparam int DIST_W  = 10;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);
   localparam logic [DIST_W-1:0]  DIST_INIT   = '1;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_PIXEL = 1'b1
   } func_type;

   // Pixel travelling down the cell row with its best match so far.
   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [DIST_W-1:0]  distance;
      logic [INDEX_W-1:0] best;
   } probe_type;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- rtl/core/npc_cell.sv -----
module npc_cell
   import npc_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   wr_en,
   input  logic [3*COLOR_W-1:0]   wr_color,
   input  logic [COUNT_W-1:0]     color_count,
   input  probe_type              up_probe,
   output probe_type              down_probe
);

   logic [3*COLOR_W-1:0] entry_ff;
   logic [DIST_W-1:0]    entry_distance;
   logic                 active;
   logic                 take;
   probe_type            probe_in;
   probe_type            probe_ff;

   // Hold this cell's palette entry {red, green, blue}.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_color;
      end
   end

   // Manhattan distance from the passing pixel to the stored entry.
   assign entry_distance = DIST_W'(abs_diff(up_probe.red,   entry_ff[3*COLOR_W-1:2*COLOR_W]))
                         + DIST_W'(abs_diff(up_probe.green, entry_ff[2*COLOR_W-1:COLOR_W]))
                         + DIST_W'(abs_diff(up_probe.blue,  entry_ff[COLOR_W-1:0]));

   // Strictly smaller wins, so the lower index keeps ties.
   assign active = COUNT_W'(CELL_INDEX) < color_count;
   assign take   = active && (entry_distance < up_probe.distance);

   always_comb begin
      probe_in = up_probe;
      if (take) begin
         probe_in.distance = entry_distance;
         probe_in.best     = INDEX_W'(CELL_INDEX);
      end
   end

   // Advance the probe to the next cell unless the row is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else if (advance) begin
         probe_ff <= probe_in;
      end
   end

   assign down_probe = probe_ff;

endmodule

// ----- rtl/core/nearest_palette_color.sv -----
// Palette quantizer: finds the palette entry nearest to a pixel by Manhattan distance.
// Request channel (req_valid/req_ready): req_func selects a palette write (entry
// req_entry_index gets req_red/green/blue) or a pixel lookup. Writes give no beat on
// the response channel; each pixel gives one rsp_palette_index beat, in order.
// csr_valid/csr_ready writes color_count (entries below color_count in the row are searched);
// csr_ready is always high. Write the register only while idle; the block does not enforce it.
// Each palette entry sits in one cell of a row of min(PALETTE_DEPTH, 256) cells; a
// pixel walks the row one cell per cycle while the row is not stalled, carrying its best match.
// A pixel's result passes every cell's register, then the response register, before it is shown.
// Throughput: one pixel per cycle unless stalled, pixels overlap in the row. A palette write
// waits until the row holds no pixel.
// Reset: the row and response register empty, color_count returns to 256; palette
// contents are undefined until written.
// Stall: with a result waiting and rsp_ready low, the row holds once the next pixel
// reaches the last cell, and req_ready stays low until the response beat is taken.
module nearest_palette_color
   import npc_pkg::*;
#(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [COLOR_W-1:0] req_red,
   input  logic [COLOR_W-1:0] req_green,
   input  logic [COLOR_W-1:0] req_blue,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INDEX_W-1:0] rsp_palette_index,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_color_count
);

   localparam int CELL_COUNT = (PALETTE_DEPTH < ADDRESSABLE_ENTRIES) ?
                               PALETTE_DEPTH : ADDRESSABLE_ENTRIES;
   localparam int FLIGHT_W   = $clog2(CELL_COUNT + 1);

   logic [COUNT_W-1:0]  count_ff;
   logic [FLIGHT_W-1:0] flight_ff;
   logic [FLIGHT_W-1:0] flight_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic                stall;
   logic                advance;
   logic                req_accept;
   logic                pixel_accept;
   logic                write_accept;
   logic                row_exit;
   probe_type           chain [CELL_COUNT+1];

   // Hold the color count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_color_count;
      end
   end

   assign csr_ready = 1'b1;

   // Stall the row when its last cell has a result and the response slot is full and not being taken.
   assign stall   = chain[CELL_COUNT].valid && rsp_valid_ff && !rsp_ready;
   assign advance = !stall;

   // Pixels enter whenever the row advances; a write also waits for the row to drain.
   assign req_ready    = advance && ((req_func == FUNC_PIXEL) || (flight_ff == '0));
   assign req_accept   = req_valid && req_ready;
   assign pixel_accept = req_accept && (req_func == FUNC_PIXEL);
   assign write_accept = req_accept && (req_func == FUNC_WRITE);
   assign row_exit     = chain[CELL_COUNT].valid && advance;

   // Count pixels inside the row.
   assign flight_in = flight_ff + FLIGHT_W'(pixel_accept) - FLIGHT_W'(row_exit);

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   // Feed the head of the row.
   always_comb begin
      chain[0].valid    = pixel_accept;
      chain[0].red      = req_red;
      chain[0].green    = req_green;
      chain[0].blue     = req_blue;
      chain[0].distance = DIST_INIT;
      chain[0].best     = '0;
   end

   // One cell per palette entry.
   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      npc_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .wr_en       (write_accept && (req_entry_index == INDEX_W'(k))),
         .wr_color    ({req_red, req_green, req_blue}),
         .color_count (count_ff),
         .up_probe    (chain[k]),
         .down_probe  (chain[k+1])
      );
   end

   // Response register: load on exit, drop when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (row_exit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (row_exit) begin
         rsp_index_ff <= chain[CELL_COUNT].best;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_index_ff;

endmodule

// ----- rtl/core/npc_checker.sv -----
`include "nearest_palette_color_assert.svh"

module npc_checker
   import npc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_func,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [INDEX_W-1:0] rsp_palette_index,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [COUNT_W-1:0] csr_color_count
);

   logic [COUNT_W-1:0] count_ff;
   logic [10:0]        pending_ff;
   logic [10:0]        pending_in;
   logic               pixel_beat;
   logic               rsp_beat;

   // Track the color count as written on the port.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_color_count;
      end
   end

   // Track pixels accepted but not yet answered.
   assign pixel_beat = req_valid && req_ready && (req_func == FUNC_PIXEL);
   assign rsp_beat   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + 11'(pixel_beat) - 11'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `NPC_ASSERT_ALWAYS(a_rsp_empty_after_reset, reset |=> !rsp_valid)
   `NPC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_palette_index))
   `NPC_ASSERT(a_rsp_needs_pixel, rsp_valid |-> pending_ff != 11'd0)
   `NPC_ASSERT(a_index_in_range,
      rsp_valid |-> ({1'b0, rsp_palette_index} < count_ff) || (rsp_palette_index == '0))

endmodule

bind nearest_palette_color npc_checker u_npc_checker (.*);

// ----- test/tb_nearest_palette_color.sv -----
module tb_nearest_palette_color;
   import npc_pkg::*;

   // Cells in the search row; a pixel result leaves the last cell into the response register.
   localparam int ROW_CELLS = (PALETTE_DEPTH_DEFAULT < ADDRESSABLE_ENTRIES) ?
                              PALETTE_DEPTH_DEFAULT : ADDRESSABLE_ENTRIES;
   localparam int SETTLE_CYCLES   = ROW_CELLS + 9;
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 16;
   localparam int MAX_REPORTS     = 10;
   localparam int DIRECTED_ROWS   = 20;

   typedef struct packed {
      func_type           func;
      logic [INDEX_W-1:0] slot;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } request_type;

   // want < 0: take the expected index from the predictor
   typedef struct {
      request_type beat;
      int          want;
   } directed_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   func_type           req_func = FUNC_WRITE;
   logic [INDEX_W-1:0] req_entry_index = '0;
   logic [COLOR_W-1:0] req_red = '0;
   logic [COLOR_W-1:0] req_green = '0;
   logic [COLOR_W-1:0] req_blue = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [INDEX_W-1:0] rsp_palette_index;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_color_count = '0;

   // Predictor state: palette contents and the programmed color count
   logic [3*COLOR_W-1:0] palette_copy [ROW_CELLS];
   logic [COUNT_W-1:0]   count_copy = COUNT_RESET;
   logic [INDEX_W-1:0]   pending_index [$];

   int failures      = 0;
   int checked_count = 0;
   int write_count   = 0;
   int pixel_count   = 0;
   int setting_count = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0},   0},
      '{'{FUNC_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255}, 255},
      '{'{FUNC_PIXEL, 8'd3,   8'd128, 8'd128, 8'd128}, 128},
      '{'{FUNC_PIXEL, 8'd0,   8'd255, 8'd0,   8'd0},   0},
      '{'{FUNC_PIXEL, 8'd0,   8'd0,   8'd255, 8'd255}, 255},
      '{'{FUNC_PIXEL, 8'd0,   8'd0,   8'd128, 8'd255}, 128},
      '{'{FUNC_PIXEL, 8'd0,   8'd10,  8'd20,  8'd200}, -1},
      '{'{FUNC_WRITE, 8'd200, 8'd5,   8'd5,   8'd5},   -1},
      '{'{FUNC_PIXEL, 8'd0,   8'd5,   8'd5,   8'd5},   5},
      '{'{FUNC_PIXEL, 8'd0,   8'd200, 8'd200, 8'd200}, 199},
      '{'{FUNC_WRITE, 8'd255, 8'd255, 8'd0,   8'd255}, -1},
      '{'{FUNC_PIXEL, 8'd0,   8'd255, 8'd0,   8'd255}, 255},
      '{'{FUNC_PIXEL, 8'd0,   8'd255, 8'd255, 8'd255}, 254},
      '{'{FUNC_WRITE, 8'd0,   8'd255, 8'd255, 8'd255}, -1},
      '{'{FUNC_PIXEL, 8'd0,   8'd255, 8'd255, 8'd255}, 0},
      '{'{FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0},   1},
      '{'{FUNC_WRITE, 8'd0,   8'd0,   8'd0,   8'd0},   -1},
      '{'{FUNC_WRITE, 8'd200, 8'd200, 8'd200, 8'd200}, -1},
      '{'{FUNC_PIXEL, 8'd0,   8'd77,  8'd140, 8'd3},   -1},
      '{'{FUNC_PIXEL, 8'd0,   8'd255, 8'd128, 8'd0},   -1}
   };

   nearest_palette_color #(
      .PALETTE_DEPTH(PALETTE_DEPTH_DEFAULT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_entry_index(req_entry_index),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_palette_index(rsp_palette_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_color_count(csr_color_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Bound the run: report errors and stop if it has not finished in time
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stall the response channel at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic flag_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%s", what);
      end
   endtask

   // Check each response beat against the oldest expected index
   always @(posedge clock) begin
      logic [INDEX_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_index.size() == 0) begin
            flag_failure($sformatf("unexpected response beat: palette index %0d",
                                   rsp_palette_index));
         end else begin
            want = pending_index.pop_front();
            checked_count++;
            if (rsp_palette_index !== want) begin
               flag_failure($sformatf("palette index mismatch: expected %0d, got %0d",
                                      want, rsp_palette_index));
            end
         end
      end
   end

   function automatic int searched_entries();
      int n;
      n = count_copy;
      if (n > ROW_CELLS) begin
         n = ROW_CELLS;
      end
      return n;
   endfunction

   // Lowest-index palette entry at the smallest Manhattan distance
   function automatic logic [INDEX_W-1:0] nearest_entry(input logic [COLOR_W-1:0] r,
                                                         input logic [COLOR_W-1:0] g,
                                                         input logic [COLOR_W-1:0] b);
      int best;
      int best_dist;
      int d;
      best = 0;
      best_dist = 1 << 30;
      for (int i = 0; i < searched_entries(); i++) begin
         d = ((r > palette_copy[i][23:16]) ? r - palette_copy[i][23:16]
                                           : palette_copy[i][23:16] - r)
           + ((g > palette_copy[i][15:8]) ? g - palette_copy[i][15:8]
                                          : palette_copy[i][15:8] - g)
           + ((b > palette_copy[i][7:0]) ? b - palette_copy[i][7:0]
                                         : palette_copy[i][7:0] - b);
         if (d < best_dist) begin
            best_dist = d;
            best = i;
         end
      end
      return best[INDEX_W-1:0];
   endfunction

   // Drive one request beat after a random gap and record its effect once accepted
   task automatic send_request(input request_type beat, input int want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= beat.func;
      req_entry_index <= beat.slot;
      req_red         <= beat.red;
      req_green       <= beat.green;
      req_blue        <= beat.blue;
      do @(posedge clock); while (!req_ready);
      if (beat.func == FUNC_WRITE) begin
         palette_copy[beat.slot] = {beat.red, beat.green, beat.blue};
         write_count++;
      end else begin
         if (want < 0) begin
            pending_index.push_back(nearest_entry(beat.red, beat.green, beat.blue));
         end else begin
            pending_index.push_back(want[INDEX_W-1:0]);
         end
         pixel_count++;
      end
   endtask

   // Hold the sender until every result is back and the row has drained
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_index.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_color_count(input logic [COUNT_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_color_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      count_copy = value;
      setting_count++;
   endtask

   initial begin
      request_type          beat;
      logic [3*COLOR_W-1:0] shade;
      logic [COUNT_W-1:0]   count_plan [PHASE_COUNT];
      logic [COUNT_W-1:0]   next_count;
      int                   item;
      int                   roll;
      int                   n;
      int                   v;

      count_plan = '{9'd1, 9'd0, 9'd511, 9'd2, 9'd256, 9'd0, 9'd0, 9'd300};
      for (int i = 0; i < ROW_CELLS; i++) begin
         palette_copy[i] = '0;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load a gray ramp: entry i holds (i, i, i)
      for (int i = 0; i < ROW_CELLS; i++) begin
         beat = '{FUNC_WRITE, i[INDEX_W-1:0], i[7:0], i[7:0], i[7:0]};
         send_request(beat, -1);
      end

      // Directed rows at the reset color count
      send_idle_pct = 18;
      rsp_idle_pct  = 88;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].beat, directed_rows[i].want);
      end

      // Random phases, each at its own color count
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_idle();
         if (phase == 5 || phase == 6) begin
            next_count = COUNT_W'($urandom_range(3, 255));
         end else begin
            next_count = count_plan[phase];
         end
         write_color_count(next_count);
         for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
            item = phase * ITEMS_PER_PHASE + j;
            if (item < PHASE_COUNT * ITEMS_PER_PHASE / 3) begin
               send_idle_pct = 18;
               rsp_idle_pct  = 88;
            end else if (item < 2 * PHASE_COUNT * ITEMS_PER_PHASE / 3) begin
               send_idle_pct = 88;
               rsp_idle_pct  = 18;
            end else begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
            n = searched_entries();
            roll = $urandom_range(0, 99);
            beat.slot = INDEX_W'($urandom_range(0, 255));
            shade = {COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom)};
            if (roll < 20) begin
               // Palette write, mostly inside the searched range, sometimes a duplicate
               beat.func = FUNC_WRITE;
               if (n > 0 && $urandom_range(0, 3) != 0) begin
                  beat.slot = INDEX_W'($urandom_range(0, n - 1));
               end
               if ($urandom_range(0, 1) == 1) begin
                  shade = palette_copy[$urandom_range(0, ROW_CELLS - 1)];
               end
            end else begin
               beat.func = FUNC_PIXEL;
               roll = $urandom_range(0, 3);
               if (roll == 1 && n > 0) begin
                  // Land next to a searched entry to stress ties and near misses
                  shade = palette_copy[$urandom_range(0, n - 1)];
                  for (int c = 0; c < 3; c++) begin
                     v = int'(shade[c*8 +: 8]) + int'($urandom_range(0, 6)) - 3;
                     if (v < 0) v = 0;
                     if (v > 255) v = 255;
                     shade[c*8 +: 8] = v[7:0];
                  end
               end else if (roll == 2) begin
                  for (int c = 0; c < 3; c++) begin
                     shade[c*8 +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                  end
               end
            end
            {beat.red, beat.green, beat.blue} = shade;
            send_request(beat, -1);
         end
      end

      wait_for_idle();
      $display("Covered %0d palette writes and %0d pixel lookups (%0d checked)",
               write_count, pixel_count, checked_count);
      $display("over %0d color-count settings, with stalls on both channels", setting_count);
      if (failures == 0 && pending_index.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (pending_index.size() != 0) begin
            $display("%0d expected palette indexes never arrived", pending_index.size());
         end
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
